@@ rtl/plru_pkg.sv @@
// ----------------------------------------------------------------------------
// Partitioned LRU package
// Shared types and constants for the partitioned LRU replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package plru_pkg;

  localparam int AGE_W  = 3;
  localparam int MASK_W = 8;
  localparam int WAY_W  = 6;
  localparam int OUT_W  = 3;

  typedef enum logic {
    KIND_ACCESS = 1'b0,
    KIND_VICTIM = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               approx;
    logic [MASK_W-1:0]  valid_mask;
    logic [MASK_W-1:0]  repl_mask;
    logic               found;
    logic               hit;
    logic [AGE_W-1:0]   best;
    logic [WAY_W-1:0]   pick;
    logic [AGE_W-1:0]   pick_age;
  } pkt_t;

  typedef struct packed {
    logic               en;
    logic               exact;
    logic [WAY_W-1:0]   way;
    logic [AGE_W-1:0]   cur_age;
  } upd_t;

endpackage

`default_nettype wire

@@ rtl/plru_cell.sv @@
// ----------------------------------------------------------------------------
// Partitioned LRU way cell
// Holds the age of one way, inspects the search packet as it passes and
// applies the broadcast age update at the end of a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module plru_cell
  import plru_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int EXACT_WAYS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pkt_t pkt_in,
  input  wire logic pkt_valid_in,
  output pkt_t      pkt_out,
  output logic      pkt_valid_out,
  input  wire upd_t upd
);

  localparam bit IS_EXACT = IDX < EXACT_WAYS;
  localparam bit IS_FIRST = IS_EXACT ? (IDX == 0) : (IDX == EXACT_WAYS);
  localparam bit HAS_MASK = IDX < MASK_W;
  localparam int POS      = IS_EXACT ? IDX : IDX - EXACT_WAYS;
  localparam logic [WAY_W-1:0] IDX_V   = WAY_W'(IDX);
  localparam logic [AGE_W-1:0] AGE_RST = AGE_W'(POS);

  logic [AGE_W-1:0] age;
  pkt_t             pkt_next;
  logic             vbit;
  logic             rbit;
  logic             in_part;

  assign vbit    = HAS_MASK ? pkt_in.valid_mask[IDX % MASK_W] : 1'b0;
  assign rbit    = HAS_MASK ? pkt_in.repl_mask[IDX % MASK_W] : 1'b0;
  assign in_part = (IS_EXACT == !pkt_in.approx);

  always_comb begin
    pkt_next = pkt_in;
    if (pkt_in.kind == KIND_ACCESS) begin
      if (pkt_in.pick == IDX_V) begin
        pkt_next.hit      = 1'b1;
        pkt_next.pick_age = age;
      end
    end else if (in_part) begin
      if (IS_FIRST) begin
        pkt_next.pick_age = age;
      end
      if (!pkt_in.found) begin
        if (!vbit) begin
          pkt_next.found    = 1'b1;
          pkt_next.pick     = IDX_V;
          pkt_next.pick_age = age;
        end else if (rbit && (age > pkt_in.best)) begin
          pkt_next.best     = age;
          pkt_next.pick     = IDX_V;
          pkt_next.pick_age = age;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid_out <= 1'b0;
    end else begin
      pkt_valid_out <= pkt_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid_in) begin
      pkt_out <= pkt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= AGE_RST;
    end else if (upd.en && (upd.exact == IS_EXACT)) begin
      if (upd.way == IDX_V) begin
        age <= '0;
      end else if (age < upd.cur_age) begin
        age <= age + AGE_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/partitioned_lru_replacement.sv @@
// ----------------------------------------------------------------------------
// Partitioned LRU replacement
// Replacement state for one cache set split into an exact and an
// approximate partition, built as a chain of per-way cells.
// ----------------------------------------------------------------------------
// Each transaction travels down a chain of ASSOC way cells, one cell per
// cycle, is captured in a final stage register in the next cycle and is
// then retired, in which cycle the age update is broadcast to all cells and
// a victim result is loaded into the output register. The block takes a new
// transaction only once the previous one has retired; a victim retire waits
// while an earlier victim result is still held and stalled in the output
// register.
`default_nettype none

module partitioned_lru_replacement
  import plru_pkg::*;
#(
  parameter int ASSOC      = 8,
  parameter int EXACT_WAYS = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              kind,
  input  wire logic [2:0]        touched_way,
  input  wire logic              approx_request,
  input  wire logic [MASK_W-1:0] valid_mask,
  input  wire logic [MASK_W-1:0] replaceable_mask,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [OUT_W-1:0]       victim_way
);

  pkt_t chain_pkt [ASSOC+1];
  logic chain_vld [ASSOC+1];
  pkt_t head;
  pkt_t fin;
  logic fin_valid;
  logic busy;
  logic accept;
  logic retire;
  upd_t upd;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_comb begin
    head            = '0;
    head.kind       = kind_t'(kind);
    head.approx     = approx_request;
    head.valid_mask = valid_mask;
    head.repl_mask  = replaceable_mask;
    if (kind_t'(kind) == KIND_ACCESS) begin
      head.pick = WAY_W'(touched_way);
    end else if (approx_request) begin
      head.pick = WAY_W'(EXACT_WAYS);
    end else begin
      head.pick = '0;
    end
  end

  assign chain_pkt[0] = head;
  assign chain_vld[0] = accept;

  for (genvar i = 0; i < ASSOC; i++) begin : g_cell
    plru_cell #(
      .IDX        (i),
      .EXACT_WAYS (EXACT_WAYS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .pkt_in        (chain_pkt[i]),
      .pkt_valid_in  (chain_vld[i]),
      .pkt_out       (chain_pkt[i+1]),
      .pkt_valid_out (chain_vld[i+1]),
      .upd           (upd)
    );
  end

  assign retire = fin_valid && ((fin.kind == KIND_ACCESS) || !out_valid || !out_stall);

  always_comb begin
    upd.en      = retire && ({1'b0, fin.pick} < (WAY_W+1)'(ASSOC)) &&
                  ((fin.kind == KIND_VICTIM) || fin.hit);
    upd.exact   = fin.pick < WAY_W'(EXACT_WAYS);
    upd.way     = fin.pick;
    upd.cur_age = fin.pick_age;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
      if (chain_vld[ASSOC]) begin
        fin_valid <= 1'b1;
      end else if (retire) begin
        fin_valid <= 1'b0;
      end
      if (retire && (fin.kind == KIND_VICTIM)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain_vld[ASSOC]) begin
      fin <= chain_pkt[ASSOC];
    end
    if (retire && (fin.kind == KIND_VICTIM)) begin
      victim_way <= fin.pick[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/plru_chk.sv @@
// ----------------------------------------------------------------------------
// Partitioned LRU port checker
// Concurrent assertions on the top-level ports, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module plru_chk
  import plru_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [OUT_W-1:0] victim_way
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(victim_way))
    else $error("victim result changed while stalled");

  // Only one transaction is in flight at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in flight");

  // A result is produced only by a transaction that was being worked on.
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no transaction in flight");

  // A result never appears in the cycle right after an accept.
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early after an accept");

endmodule

bind partitioned_lru_replacement plru_chk u_plru_chk (.*);

`default_nettype wire
